FILE: rtl/core/rsc_pkg.sv
// ----------------------------------------------------------------------------
// rsc_pkg: shared types for the RPN stack calculator
// Command codes, the sequencer state type and the result beat structure.
// ----------------------------------------------------------------------------
package rsc_pkg;

	localparam int DATA_W = 16;
	localparam int ACT_W  = 4;

	typedef enum logic [ACT_W-1:0] {
		ACT_ENTER = 4'd0,
		ACT_CLEAR = 4'd1,
		ACT_POP   = 4'd2,
		ACT_TOP   = 4'd3,
		ACT_SHL   = 4'd4,
		ACT_SHR   = 4'd5,
		ACT_OR    = 4'd6,
		ACT_AND   = 4'd7,
		ACT_ADD   = 4'd8
	} action_t;

	typedef enum logic {
		ST_IDLE = 1'b0,
		ST_EXEC = 1'b1
	} state_t;

	typedef struct packed {
		logic              valid;
		logic [DATA_W-1:0] value;
		logic              rejected;
	} result_t;

endpackage

FILE: rtl/core/rsc_ram.sv
// ----------------------------------------------------------------------------
// rsc_ram: generic RAM, one write port and two registered read ports
// Read data is registered: it appears in the cycle after the address.
// ----------------------------------------------------------------------------
module rsc_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr_a,
	input  logic [$clog2(DEPTH)-1:0] raddr_b,
	output logic [WIDTH-1:0]         rdata_a,
	output logic [WIDTH-1:0]         rdata_b
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata_a <= mem[raddr_a];
		rdata_b <= mem[raddr_b];
	end

endmodule

FILE: rtl/core/rsc_alu.sv
// ----------------------------------------------------------------------------
// rsc_alu: command evaluation for the RPN stack calculator
// From the command, the top two entries and the fill count it forms the
// stack write, the next fill count and the result beat.
// ----------------------------------------------------------------------------
module rsc_alu
	import rsc_pkg::*;
#(
	parameter int STACK_DEPTH = 16
) (
	input  logic [ACT_W-1:0]                   action,
	input  logic [DATA_W-1:0]                  operand_value,
	input  logic [DATA_W-1:0]                  top_a,
	input  logic [DATA_W-1:0]                  next_b,
	input  logic [$clog2(STACK_DEPTH+1)-1:0]   count,
	output logic                               we,
	output logic [$clog2(STACK_DEPTH)-1:0]     waddr,
	output logic [DATA_W-1:0]                  wdata,
	output logic [$clog2(STACK_DEPTH+1)-1:0]   count_next,
	output result_t                            result
);

	localparam int CW = $clog2(STACK_DEPTH + 1);
	localparam int AW = $clog2(STACK_DEPTH);

	logic              shift_big;
	logic [DATA_W:0]   sum;
	logic [DATA_W-1:0] bin_r;
	logic              bin_ok;
	logic [CW-1:0]     count_m1;
	logic [CW-1:0]     count_m2;

	assign count_m1  = count - CW'(1);
	assign count_m2  = count - CW'(2);
	assign shift_big = |top_a[DATA_W-1:4];
	assign sum       = {1'b0, top_a} + {1'b0, next_b};

	always_comb begin
		bin_r  = '0;
		bin_ok = 1'b1;
		unique case (action)
			ACT_SHL: bin_r = shift_big ? '0 : (next_b << top_a[3:0]);
			ACT_SHR: bin_r = shift_big ? '0 : (next_b >> top_a[3:0]);
			ACT_OR:  bin_r = top_a | next_b;
			ACT_AND: bin_r = top_a & next_b;
			ACT_ADD: begin
				bin_r  = sum[DATA_W-1:0];
				bin_ok = !sum[DATA_W];
			end
			default: bin_r = '0;
		endcase
	end

	always_comb begin
		we         = 1'b0;
		waddr      = count[AW-1:0];
		wdata      = operand_value;
		count_next = count;
		result     = '0;
		unique case (action)
			ACT_ENTER: begin
				if (count == CW'(STACK_DEPTH)) begin
					result.valid    = 1'b1;
					result.value    = top_a;
					result.rejected = 1'b1;
				end else begin
					we           = 1'b1;
					count_next   = count + CW'(1);
					result.valid = 1'b1;
					result.value = operand_value;
				end
			end
			ACT_CLEAR: count_next = '0;
			ACT_POP: begin
				if (count != '0) begin
					count_next = count_m1;
					// The entry below the old top becomes the new top.
					if (count_m1 != '0) begin
						result.valid = 1'b1;
						result.value = next_b;
					end
				end
			end
			ACT_TOP: begin
				if (count != '0) begin
					result.valid = 1'b1;
					result.value = top_a;
				end
			end
			ACT_SHL, ACT_SHR, ACT_OR, ACT_AND, ACT_ADD: begin
				if (count >= CW'(2) && bin_ok) begin
					we           = 1'b1;
					waddr        = count_m2[AW-1:0];
					wdata        = bin_r;
					count_next   = count_m1;
					result.valid = 1'b1;
					result.value = bin_r;
				end
			end
			default: result = '0;
		endcase
	end

endmodule

FILE: rtl/core/rpn_stack_calculator_top.sv
// ----------------------------------------------------------------------------
// rpn_stack_calculator_top: 16-bit reverse-Polish stack calculator
//
// One command beat (action, operand_value) enters on in_valid/in_ready and
// yields exactly one result beat (result_valid, result_value, push_rejected)
// on out_valid/out_ready. The stack lives in a two-read-port RAM; the top
// two entries are read in the cycle a command is accepted and are evaluated
// and written back once the output register can take the result.
// The result beat is registered and offered once the command commits. Each
// command takes the RAM read and then the read-modify-write before the block
// returns to idle; only one command is in flight.
// The result sits in an output register, so a new command is accepted while
// a result waits. If the receiver stalls, the second command holds in its
// evaluation cycle until the output register frees.
// Reset empties the stack (fill count zero); the RAM itself is not cleared,
// and no entry's data is used before it has been written.
// ----------------------------------------------------------------------------
module rpn_stack_calculator_top
	import rsc_pkg::*;
#(
	parameter int STACK_DEPTH = 16
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_ready,
	input  logic [ACT_W-1:0]  action,
	input  logic [DATA_W-1:0] operand_value,
	output logic              out_valid,
	input  logic              out_ready,
	output logic              result_valid,
	output logic [DATA_W-1:0] result_value,
	output logic              push_rejected
);

	localparam int CW = $clog2(STACK_DEPTH + 1);
	localparam int AW = $clog2(STACK_DEPTH);

	state_t            state_q, state_d;
	logic [CW-1:0]     count_q;
	logic [ACT_W-1:0]  action_q;
	logic [DATA_W-1:0] operand_q;
	logic              out_valid_q;
	result_t           result_q;

	logic              accept;
	logic              commit;
	logic [CW-1:0]     count_m1;
	logic [CW-1:0]     count_m2;
	logic [DATA_W-1:0] top_a;
	logic [DATA_W-1:0] next_b;
	logic              alu_we;
	logic [AW-1:0]     alu_waddr;
	logic [DATA_W-1:0] alu_wdata;
	logic [CW-1:0]     alu_count;
	result_t           alu_result;

	assign count_m1 = count_q - CW'(1);
	assign count_m2 = count_q - CW'(2);

	// Reads always follow the live count, so the data stays valid while a
	// command waits in evaluation for the output register.
	rsc_ram #(
		.WIDTH (DATA_W),
		.DEPTH (STACK_DEPTH)
	) u_stack_ram (
		.clk     (clk),
		.we      (commit && alu_we),
		.waddr   (alu_waddr),
		.wdata   (alu_wdata),
		.raddr_a (count_m1[AW-1:0]),
		.raddr_b (count_m2[AW-1:0]),
		.rdata_a (top_a),
		.rdata_b (next_b)
	);

	rsc_alu #(
		.STACK_DEPTH (STACK_DEPTH)
	) u_alu (
		.action        (action_q),
		.operand_value (operand_q),
		.top_a         (top_a),
		.next_b        (next_b),
		.count         (count_q),
		.we            (alu_we),
		.waddr         (alu_waddr),
		.wdata         (alu_wdata),
		.count_next    (alu_count),
		.result        (alu_result)
	);

	always_comb begin
		state_d  = state_q;
		in_ready = 1'b0;
		commit   = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					state_d = ST_EXEC;
				end
			end
			ST_EXEC: begin
				if (!out_valid_q || out_ready) begin
					commit  = 1'b1;
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	assign accept = in_valid && in_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			count_q     <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (commit) begin
				count_q     <= alu_count;
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			action_q  <= action;
			operand_q <= operand_value;
		end
		if (commit) begin
			result_q <= alu_result;
		end
	end

	assign out_valid     = out_valid_q;
	assign result_valid  = result_q.valid;
	assign result_value  = result_q.value;
	assign push_rejected = result_q.rejected;

	a_count_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CW'(STACK_DEPTH))
		else $error("stack fill count exceeds the stack depth");

	a_single_in_flight: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> !in_ready)
		else $error("second command accepted while one is being evaluated");

	a_reject_has_top: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && push_rejected) |-> result_valid)
		else $error("rejected push without a valid top value");

	a_null_is_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && !result_valid) |-> (result_value == '0 && !push_rejected))
		else $error("null result carries data");

endmodule

FILE: dv/rsc_stack_checker.sv
// ----------------------------------------------------------------------------
// rsc_stack_checker: result checker for the RPN stack calculator
// Watches the command and result channels, keeps a shadow stack that it
// updates on every accepted command beat, and compares each result beat
// field by field with the oldest outstanding prediction.
// ----------------------------------------------------------------------------
module rsc_stack_checker
	import rsc_pkg::*;
#(
	parameter int STACK_DEPTH = 16
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	input  logic              in_ready,
	input  logic [ACT_W-1:0]  action,
	input  logic [DATA_W-1:0] operand_value,
	input  logic              out_valid,
	input  logic              out_ready,
	input  logic              result_valid,
	input  logic [DATA_W-1:0] result_value,
	input  logic              push_rejected,
	output int                fail_count,
	output int                pending
);
	timeunit 1ns;
	timeprecision 1ps;

	logic [DATA_W-1:0] shadow_stack [STACK_DEPTH];
	int unsigned       shadow_depth;
	result_t           due_results [$];

	initial fail_count = 0;

	task automatic report_mismatch(input string what, input logic [DATA_W+1:0] got,
			input logic [DATA_W+1:0] want);
		$display("%0t ns: %s mismatch, got %h expected %h", $time, what, got, want);
		fail_count++;
	endtask

	// Applies one command to the shadow stack and returns the beat it must produce.
	function automatic result_t apply_command(input logic [ACT_W-1:0] act,
			input logic [DATA_W-1:0] val);
		result_t           res;
		logic [DATA_W-1:0] a;
		logic [DATA_W-1:0] b;
		logic [DATA_W:0]   sum;
		res = '0;
		case (act)
		ACT_ENTER: begin
			if (shadow_depth >= STACK_DEPTH) begin
				res.valid    = 1'b1;
				res.value    = shadow_stack[STACK_DEPTH-1];
				res.rejected = 1'b1;
			end else begin
				shadow_stack[shadow_depth] = val;
				shadow_depth++;
				res.valid = 1'b1;
				res.value = val;
			end
		end
		ACT_CLEAR: shadow_depth = 0;
		ACT_POP: begin
			if (shadow_depth > 0) begin
				shadow_depth--;
				if (shadow_depth > 0) begin
					res.valid = 1'b1;
					res.value = shadow_stack[shadow_depth-1];
				end
			end
		end
		ACT_TOP: begin
			if (shadow_depth > 0) begin
				res.valid = 1'b1;
				res.value = shadow_stack[shadow_depth-1];
			end
		end
		ACT_SHL, ACT_SHR, ACT_OR, ACT_AND, ACT_ADD: begin
			if (shadow_depth >= 2) begin
				a   = shadow_stack[shadow_depth-1];
				b   = shadow_stack[shadow_depth-2];
				sum = {1'b0, a} + {1'b0, b};
				// An add that carries out leaves both operands where they were.
				if (!(act == ACT_ADD && sum[DATA_W])) begin
					if (act == ACT_SHL)
						res.value = (a >= DATA_W) ? '0 : (b << a);
					else if (act == ACT_SHR)
						res.value = (a >= DATA_W) ? '0 : (b >> a);
					else if (act == ACT_OR)
						res.value = a | b;
					else if (act == ACT_AND)
						res.value = a & b;
					else
						res.value = sum[DATA_W-1:0];
					res.valid = 1'b1;
					shadow_depth--;
					shadow_stack[shadow_depth-1] = res.value;
				end
			end
		end
		default: ;
		endcase
		return res;
	endfunction

	// The result beat retires before the command beat of the same edge is
	// predicted, since a result always belongs to an earlier command.
	always @(posedge clk or negedge arst_n) begin
		result_t want;
		if (!arst_n) begin
			shadow_depth = 0;
			due_results.delete();
			pending = 0;
		end else begin
			if (out_valid && out_ready) begin
				if (due_results.size() == 0) begin
					report_mismatch("unexpected result beat",
						{result_valid, result_value, push_rejected}, '0);
				end else begin
					want = due_results.pop_front();
					if (result_valid !== want.valid)
						report_mismatch("result_valid", (DATA_W+2)'(result_valid),
							(DATA_W+2)'(want.valid));
					if (result_value !== want.value)
						report_mismatch("result_value", (DATA_W+2)'(result_value),
							(DATA_W+2)'(want.value));
					if (push_rejected !== want.rejected)
						report_mismatch("push_rejected", (DATA_W+2)'(push_rejected),
							(DATA_W+2)'(want.rejected));
				end
			end
			if (in_valid && in_ready)
				due_results = {due_results, apply_command(action, operand_value)};
			pending = due_results.size();
		end
	end

endmodule

FILE: dv/rpn_stack_calculator_top_test.sv
// ----------------------------------------------------------------------------
// rpn_stack_calculator_top_test: regression for the RPN stack calculator
// Drives a directed opening over the corner cases, then random command
// sequences (expressions, stack fills, walks, short stacks and noise) with
// random gaps on the command side and random stalls on the result side.
// The checker module beside the block predicts and compares every result.
// ----------------------------------------------------------------------------
module rpn_stack_calculator_top_test
	import rsc_pkg::*;
();
	timeunit 1ns;
	timeprecision 1ps;

	localparam int STACK_DEPTH    = 16;
	localparam int TOTAL_ITEMS    = 1300;
	localparam int WATCHDOG_LIMIT = 2000;
	localparam int DRAIN_CYCLES   = 10;

	// Codes outside the command set; the block must treat them as no-ops.
	localparam logic [ACT_W-1:0] ACT_UNUSED_LO = 4'd9;
	localparam logic [ACT_W-1:0] ACT_UNUSED_HI = 4'd15;

	logic              clk;
	logic              arst_n;
	logic              in_valid;
	logic              in_ready;
	logic [ACT_W-1:0]  action;
	logic [DATA_W-1:0] operand_value;
	logic              out_valid;
	logic              out_ready;
	logic              result_valid;
	logic [DATA_W-1:0] result_value;
	logic              push_rejected;
	int                fail_count;
	int                pending;
	int                items_sent;
	int                stall_cycles;
	bit                burst_mode;

	rpn_stack_calculator_top #(
		.STACK_DEPTH(STACK_DEPTH)
	) dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (in_valid),
		.in_ready     (in_ready),
		.action       (action),
		.operand_value(operand_value),
		.out_valid    (out_valid),
		.out_ready    (out_ready),
		.result_valid (result_valid),
		.result_value (result_value),
		.push_rejected(push_rejected)
	);

	rsc_stack_checker #(
		.STACK_DEPTH(STACK_DEPTH)
	) checker_i (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (in_valid),
		.in_ready     (in_ready),
		.action       (action),
		.operand_value(operand_value),
		.out_valid    (out_valid),
		.out_ready    (out_ready),
		.result_valid (result_valid),
		.result_value (result_value),
		.push_rejected(push_rejected),
		.fail_count   (fail_count),
		.pending      (pending)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (burst_mode || r < 45)
			return 0;
		if (r < 85)
			return $urandom_range(1, 3);
		if (r < 96)
			return $urandom_range(4, 12);
		return $urandom_range(25, 60);
	endfunction

	// Small values are favored so that shift amounts land around the width.
	function automatic logic [DATA_W-1:0] pick_operand();
		int r;
		r = $urandom_range(0, 99);
		if (r < 30)
			return DATA_W'($urandom_range(0, DATA_W + 3));
		if (r < 42) begin
			case ($urandom_range(0, 3))
			0: return '0;
			1: return '1;
			2: return 16'h8000;
			default: return 16'h7FFF;
			endcase
		end
		return DATA_W'($urandom());
	endfunction

	function automatic logic [ACT_W-1:0] pick_binary();
		return action_t'($urandom_range(ACT_SHL, ACT_ADD));
	endfunction

	// Presents one command beat and returns at the edge that accepts it.
	task automatic send_beat(input logic [ACT_W-1:0] act, input logic [DATA_W-1:0] val);
		int gap;
		gap = pick_gap();
		@(negedge clk);
		if (gap > 0) begin
			in_valid = 1'b0;
			repeat (gap) @(negedge clk);
		end
		in_valid      = 1'b1;
		action        = act;
		operand_value = val;
		do @(posedge clk); while (!in_ready);
		if (act <= ACT_ADD)
			items_sent++;
	endtask

	task automatic run_opening();
		send_beat(ACT_TOP, 16'h0000);
		send_beat(ACT_POP, 16'h0000);
		send_beat(ACT_ADD, 16'h0000);
		send_beat(ACT_ENTER, 16'hFFFF);
		send_beat(ACT_SHR, 16'h0000);
		send_beat(ACT_ENTER, 16'h0001);
		send_beat(ACT_ADD, 16'hFFFF);
		send_beat(ACT_TOP, 16'h0000);
		send_beat(ACT_ENTER, 16'h0010);
		send_beat(ACT_SHL, 16'h0000);
		send_beat(ACT_POP, 16'h0000);
		send_beat(ACT_ENTER, 16'h000F);
		send_beat(ACT_SHL, 16'h0000);
		send_beat(ACT_ENTER, 16'h000F);
		send_beat(ACT_SHR, 16'h0000);
		send_beat(ACT_ENTER, 16'h0011);
		send_beat(ACT_SHR, 16'h0000);
		send_beat(ACT_ENTER, 16'hA5A5);
		send_beat(ACT_OR, 16'h0000);
		send_beat(ACT_ENTER, 16'h5A5A);
		send_beat(ACT_AND, 16'h0000);
		send_beat(ACT_UNUSED_LO, 16'hFFFF);
		send_beat(ACT_UNUSED_HI, 16'h0000);
		send_beat(ACT_POP, 16'h0000);
		send_beat(ACT_CLEAR, 16'hFFFF);
	endtask

	// Pushes k operands and folds them with k-1 binary commands, with random top queries between.
	task automatic send_expression();
		int k;
		k = $urandom_range(2, 5);
		repeat (k) send_beat(ACT_ENTER, pick_operand());
		repeat (k - 1) begin
			if ($urandom_range(0, 99) < 20)
				send_beat(ACT_TOP, DATA_W'($urandom()));
			send_beat(pick_binary(), DATA_W'($urandom()));
		end
	endtask

	// Runs the stack past full so that pushes get rejected.
	task automatic send_fill();
		if ($urandom_range(0, 1))
			send_beat(ACT_CLEAR, DATA_W'($urandom()));
		repeat (STACK_DEPTH + $urandom_range(1, 3)) send_beat(ACT_ENTER, pick_operand());
		repeat ($urandom_range(1, 4)) send_beat(pick_binary(), DATA_W'($urandom()));
	endtask

	task automatic send_walk();
		repeat ($urandom_range(2, 6))
			send_beat($urandom_range(0, 1) ? ACT_POP : ACT_TOP, DATA_W'($urandom()));
	endtask

	// Commands against an empty or single-entry stack.
	task automatic send_short_stack();
		send_beat(ACT_CLEAR, DATA_W'($urandom()));
		if ($urandom_range(0, 1))
			send_beat(ACT_ENTER, pick_operand());
		repeat (2) send_beat(pick_binary(), DATA_W'($urandom()));
		if ($urandom_range(0, 1))
			send_beat($urandom_range(0, 1) ? ACT_POP : ACT_TOP, DATA_W'($urandom()));
	endtask

	task automatic send_noise();
		repeat ($urandom_range(1, 4))
			send_beat(ACT_W'($urandom_range(ACT_ENTER, ACT_UNUSED_HI)),
				DATA_W'($urandom()));
	endtask

	initial begin
		int kind;
		arst_n        = 1'b0;
		in_valid      = 1'b0;
		action        = ACT_ENTER;
		operand_value = '0;
		items_sent    = 0;
		burst_mode    = 1'b0;
		repeat (7) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		run_opening();
		while (items_sent < TOTAL_ITEMS) begin
			burst_mode = ($urandom_range(0, 99) < 15);
			kind       = $urandom_range(0, 99);
			if (kind < 55)
				send_expression();
			else if (kind < 65)
				send_fill();
			else if (kind < 75)
				send_walk();
			else if (kind < 85)
				send_short_stack();
			else
				send_noise();
		end
		@(negedge clk);
		in_valid = 1'b0;
		while (pending != 0) @(negedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (fail_count == 0)
			$display("[ OK ] regression clean");
		else
			$display("[FAIL] regression broken");
		$finish;
	end

	// Result side: stretches of steady ready, a few long stalls, and
	// per-cycle random stalls in between.
	initial begin
		int pick;
		out_ready = 1'b0;
		@(posedge arst_n);
		forever begin
			pick = $urandom_range(0, 99);
			if (pick < 20) begin
				out_ready = 1'b1;
				repeat ($urandom_range(20, 80)) @(negedge clk);
			end else if (pick < 24) begin
				out_ready = 1'b0;
				repeat ($urandom_range(20, 60)) @(negedge clk);
			end else begin
				out_ready = ($urandom_range(0, 99) < 65);
				@(negedge clk);
			end
		end
	end

	// Ends the run when neither channel has moved a beat for too long.
	initial begin
		stall_cycles = 0;
		while (stall_cycles < WATCHDOG_LIMIT) begin
			@(posedge clk);
			if ((in_valid && in_ready) || (out_valid && out_ready))
				stall_cycles = 0;
			else
				stall_cycles++;
		end
		$display("[FAIL] regression broken");
		$finish;
	end

endmodule

FILE: sim.f
rtl/core/rsc_pkg.sv
rtl/core/rsc_ram.sv
rtl/core/rsc_alu.sv
rtl/core/rpn_stack_calculator_top.sv
dv/rsc_stack_checker.sv
dv/rpn_stack_calculator_top_test.sv
